>>> src/tlwn_pkg.sv
// Shared constants, codes and character classes for the token lexer.
package tlwn_pkg;
   localparam int NAME_LEN_DEF = 8;
   localparam int TABLE_DEPTH_DEF = 32;
   localparam int BUF_W = 64;
   localparam int ID_W = 6;

   localparam logic [2:0] TK_OP = 3'd0;
   localparam logic [2:0] TK_SYM = 3'd1;
   localparam logic [2:0] TK_KW = 3'd2;
   localparam logic [2:0] TK_ID = 3'd3;
   localparam logic [2:0] TK_NUM = 3'd4;
   localparam logic [2:0] TK_STR = 3'd5;
   localparam logic [2:0] TK_BAD = 3'd6;
   localparam logic [2:0] TK_FULL = 3'd7;

   localparam logic [63:0] KW_INT = 64'h0000_0000_0074_6E69;
   localparam logic [63:0] KW_CHAR = 64'h0000_0000_7261_6863;
   localparam logic [63:0] KW_FLOAT = 64'h0000_0074_616F_6C66;
   localparam logic [63:0] KW_MAIN = 64'h0000_0000_6E69_616D;

   typedef enum logic [5:0] {
      MD_IDLE = 6'b000001,
      MD_LT   = 6'b000010,
      MD_GT   = 6'b000100,
      MD_EQ   = 6'b001000,
      MD_WORD = 6'b010000,
      MD_STR  = 6'b100000
   } mode_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_PROC  = 6'b000010,
      S_WORD  = 6'b000100,
      S_CHARS = 6'b001000,
      S_BYTE  = 6'b010000,
      S_SYM   = 6'b100000
   } state_type;

   function automatic logic is_digit(input logic [7:0] c);
      return c >= 8'h30 && c <= 8'h39;
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
   endfunction

   function automatic logic is_word(input logic [7:0] c);
      return is_digit(c) || is_alpha(c) || c == 8'h5F;
   endfunction

   function automatic logic is_op(input logic [7:0] c);
      return c == 8'h2B || c == 8'h2D || c == 8'h2A || c == 8'h2F || c == 8'h25;
   endfunction

   function automatic logic is_sym(input logic [7:0] c);
      return c == 8'h3B || c == 8'h2C || c == 8'h28 || c == 8'h29 || c == 8'h27
         || c == 8'h3A;
   endfunction

   // byte seen in idle mode yields a beat
   function automatic logic byte_emits(input logic [7:0] c);
      return is_op(c) || is_sym(c) || c == 8'h22;
   endfunction
endpackage

>>> src/tlwn_cell.sv
// One name table entry; passes the hit number along the chain.
module tlwn_cell import tlwn_pkg::*; #(
   parameter logic [ID_W-1:0] CELL_NUM = 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [BUF_W-1:0] key,
   input  logic             active,
   input  logic [ID_W-1:0]  num_in,
   output logic [ID_W-1:0]  num_out
);
   logic [BUF_W-1:0] entry_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_ff <= key;
      end
   end

   // names are unique, so at most one cell hits and the numbers can be ORed
   assign num_out = num_in | ((active && entry_ff == key) ? CELL_NUM : '0);
endmodule

>>> src/token_lexer_with_name_table_unit.sv
// Top level: byte scanner, token sequencer and the name table cell chain.
// A beat is accepted only in S_IDLE; it then passes through S_PROC and, as needed, S_WORD,
// S_CHARS, S_SYM or S_BYTE before the next beat is accepted. S_PROC and the later states
// wait while the output register holds a result not yet taken.
// The name table cells are searched combinationally.
// Reset: synchronous, clears scan mode, lexeme and entry count; entries are undefined.
module token_lexer_with_name_table_unit import tlwn_pkg::*; #(
   parameter int NAME_LEN = NAME_LEN_DEF,
   parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // byte_req[7:0]
   input  logic        req_tuser,   // kind[0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // lexeme_char[7:0] second_char[15:8] keyword_index[17:16]
                                    // identifier_number[23:18] lexeme_end[24] too_long[25]
   output logic [2:0]  rsp_tuser,   // token_kind[2:0]
   output logic        rsp_tlast
);
   state_type st_ff, st_in;
   mode_type mode_ff, mode_in;
   logic [BUF_W-1:0] buf_ff, buf_in;
   logic [3:0] len_ff, len_in;
   logic sd_ff, sd_in, hl_ff, hl_in, ov_ff, ov_in;
   logic [ID_W-1:0] cnt_ff, cnt_in;
   logic kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic [2:0] idx_ff, idx_in;
   logic [2:0] chk_ff, chk_in;
   logic sym_ff, sym_in;

   logic o_valid_ff;
   logic [2:0] o_kind_ff;
   logic [7:0] o_ch_ff, o_sec_ff;
   logic [1:0] o_kw_ff;
   logic [ID_W-1:0] o_id_ff;
   logic o_end_ff, o_tl_ff, o_last_ff;

   logic emit, can_emit, more, lastc, wr_en;
   logic [2:0] e_kind;
   logic [7:0] e_ch, e_sec;
   logic [1:0] e_kw;
   logic [ID_W-1:0] e_id;
   logic e_end, e_tl, e_last;
   logic [ID_W-1:0] hit_num [TABLE_DEPTH+1];

   assign hit_num[0] = '0;
   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      tlwn_cell #(.CELL_NUM(ID_W'(i + 1))) u_cell (
         .clock   (clock),
         .wr_en   (wr_en && cnt_ff == ID_W'(i)),
         .key     (buf_ff),
         .active  (cnt_ff > ID_W'(i)),
         .num_in  (hit_num[i]),
         .num_out (hit_num[i+1])
      );
   end

   assign can_emit = !o_valid_ff || rsp_tready;
   assign more = !kind_ff && byte_emits(byte_ff);
   assign lastc = len_ff == 4'd0 || ({1'b0, idx_ff} + 4'd1) == len_ff;
   assign req_tready = st_ff == S_IDLE;

   always_comb begin
      st_in = st_ff; mode_in = mode_ff; buf_in = buf_ff; len_in = len_ff;
      sd_in = sd_ff; hl_in = hl_ff; ov_in = ov_ff; cnt_in = cnt_ff;
      kind_in = kind_ff; byte_in = byte_ff; idx_in = idx_ff; chk_in = chk_ff;
      sym_in = sym_ff; wr_en = 1'b0;
      emit = 1'b0; e_kind = TK_OP; e_ch = '0; e_sec = '0; e_kw = '0; e_id = '0;
      e_end = 1'b0; e_tl = 1'b0; e_last = 1'b1;
      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in = req_tuser;
               byte_in = req_tdata;
               st_in = S_PROC;
            end
         end
         S_PROC: begin
            if (can_emit) begin
               st_in = S_IDLE;
               if (kind_ff) begin
                  mode_in = MD_IDLE;
                  unique case (mode_ff)
                     MD_LT: begin emit = 1'b1; e_ch = 8'h3C; end
                     MD_GT: begin emit = 1'b1; e_ch = 8'h3E; end
                     MD_EQ: begin emit = 1'b1; e_kind = TK_SYM; e_ch = 8'h3D; end
                     MD_WORD: st_in = S_WORD;
                     MD_STR: begin
                        chk_in = TK_STR; sym_in = 1'b0; idx_in = '0; st_in = S_CHARS;
                     end
                     default: ;
                  endcase
               end else begin
                  unique case (mode_ff) inside
                     MD_LT, MD_GT, MD_EQ: begin
                        emit = 1'b1;
                        mode_in = MD_IDLE;
                        e_ch = (mode_ff == MD_LT) ? 8'h3C : (mode_ff == MD_GT) ? 8'h3E : 8'h3D;
                        if (byte_ff == 8'h3D) begin
                           e_sec = 8'h3D;
                        end else begin
                           e_kind = (mode_ff == MD_EQ) ? TK_SYM : TK_OP;
                           e_last = !byte_emits(byte_ff);
                           st_in = S_BYTE;
                        end
                     end
                     MD_WORD: begin
                        if (is_word(byte_ff)) begin
                           if (!is_digit(byte_ff)) hl_in = 1'b1;
                           if (len_ff < 4'(NAME_LEN)) begin
                              buf_in[len_ff[2:0]*8 +: 8] = byte_ff;
                              len_in = len_ff + 4'd1;
                           end else begin
                              ov_in = 1'b1;
                           end
                        end else begin
                           mode_in = MD_IDLE;
                           st_in = S_WORD;
                        end
                     end
                     MD_STR: begin
                        if (is_alpha(byte_ff)) begin
                           if (len_ff < 4'(NAME_LEN)) begin
                              buf_in[len_ff[2:0]*8 +: 8] = byte_ff;
                              len_in = len_ff + 4'd1;
                           end else begin
                              ov_in = 1'b1;
                           end
                        end else begin
                           mode_in = MD_IDLE;
                           chk_in = TK_STR; sym_in = 1'b1; idx_in = '0; st_in = S_CHARS;
                        end
                     end
                     default: st_in = S_BYTE;
                  endcase
               end
            end
         end
         S_WORD: begin
            if (can_emit) begin
               st_in = kind_ff ? S_IDLE : S_BYTE;
               e_last = !more;
               e_tl = ov_ff;
               if (!ov_ff && (buf_ff == KW_INT || buf_ff == KW_CHAR || buf_ff == KW_FLOAT
                     || buf_ff == KW_MAIN)) begin
                  emit = 1'b1;
                  e_kind = TK_KW;
                  e_tl = 1'b0;
                  e_kw = (buf_ff == KW_INT) ? 2'd0 : (buf_ff == KW_CHAR) ? 2'd1 :
                         (buf_ff == KW_FLOAT) ? 2'd2 : 2'd3;
               end else if (sd_ff) begin
                  chk_in = hl_ff ? TK_BAD : TK_NUM;
                  sym_in = 1'b0; idx_in = '0; st_in = S_CHARS;
               end else if (hit_num[TABLE_DEPTH] != '0) begin
                  emit = 1'b1; e_kind = TK_ID; e_id = hit_num[TABLE_DEPTH];
               end else if (cnt_ff < ID_W'(TABLE_DEPTH)) begin
                  emit = 1'b1; e_kind = TK_ID; e_id = cnt_ff + 1'b1;
                  wr_en = 1'b1; cnt_in = cnt_ff + 1'b1;
               end else begin
                  emit = 1'b1; e_kind = TK_FULL;
               end
            end
         end
         S_CHARS: begin
            if (can_emit) begin
               emit = 1'b1;
               e_kind = chk_ff;
               e_ch = (len_ff == 4'd0) ? 8'h00 : buf_ff[idx_ff*8 +: 8];
               e_end = lastc;
               e_tl = ov_ff;
               e_last = lastc && !sym_ff && !more;
               idx_in = idx_ff + 3'd1;
               if (lastc) st_in = sym_ff ? S_SYM : (kind_ff ? S_IDLE : S_BYTE);
            end
         end
         S_SYM: begin
            if (can_emit) begin
               emit = 1'b1; e_kind = TK_SYM; e_ch = byte_ff; st_in = S_IDLE;
            end
         end
         S_BYTE: begin
            if (can_emit) begin
               st_in = S_IDLE;
               mode_in = MD_IDLE;
               e_ch = byte_ff;
               if (byte_ff == 8'h3C) mode_in = MD_LT;
               else if (byte_ff == 8'h3E) mode_in = MD_GT;
               else if (byte_ff == 8'h3D) mode_in = MD_EQ;
               else if (is_op(byte_ff)) emit = 1'b1;
               else if (is_sym(byte_ff)) begin emit = 1'b1; e_kind = TK_SYM; end
               else if (is_word(byte_ff)) begin
                  buf_in = {{(BUF_W-8){1'b0}}, byte_ff};
                  len_in = 4'd1; ov_in = 1'b0;
                  sd_in = is_digit(byte_ff); hl_in = !is_digit(byte_ff);
                  mode_in = MD_WORD;
               end else if (byte_ff == 8'h22) begin
                  emit = 1'b1; e_kind = TK_SYM;
                  buf_in = '0; len_in = '0; ov_in = 1'b0; sd_in = 1'b0; hl_in = 1'b0;
                  mode_in = MD_STR;
               end
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; mode_ff <= MD_IDLE; buf_ff <= '0; len_ff <= '0;
         sd_ff <= 1'b0; hl_ff <= 1'b0; ov_ff <= 1'b0; cnt_ff <= '0; o_valid_ff <= 1'b0;
      end else begin
         st_ff <= st_in; mode_ff <= mode_in; buf_ff <= buf_in; len_ff <= len_in;
         sd_ff <= sd_in; hl_ff <= hl_in; ov_ff <= ov_in; cnt_ff <= cnt_in;
         if (emit) o_valid_ff <= 1'b1;
         else if (rsp_tready) o_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in; byte_ff <= byte_in; idx_ff <= idx_in; chk_ff <= chk_in;
      sym_ff <= sym_in;
      if (emit) begin
         o_kind_ff <= e_kind; o_ch_ff <= e_ch; o_sec_ff <= e_sec; o_kw_ff <= e_kw;
         o_id_ff <= e_id; o_end_ff <= e_end; o_tl_ff <= e_tl; o_last_ff <= e_last;
      end
   end

   assign rsp_tvalid = o_valid_ff;
   assign rsp_tuser = o_kind_ff;
   assign rsp_tlast = o_last_ff;
   assign rsp_tdata = {6'b0, o_tl_ff, o_end_ff, o_id_ff, o_kw_ff, o_sec_ff, o_ch_ff};

`ifndef SYNTH
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ID_W'(TABLE_DEPTH)) else $error("entry count over depth");
   a_len: assert property (@(posedge clock) disable iff (reset)
      len_ff <= 4'(NAME_LEN)) else $error("lexeme length over limit");
   a_id: assert property (@(posedge clock) disable iff (reset)
      emit && e_kind == TK_ID |-> e_id != '0 && e_id <= cnt_in)
      else $error("bad identifier number");
   a_emit: assert property (@(posedge clock) disable iff (reset)
      emit |-> can_emit) else $error("result overwritten");
`endif
endmodule
